>>> src/mcoc_pkg.sv
// ----------------------------------------------------------------------------
// mcoc_pkg
// Shared widths, types and helpers of the matrix chain order cost block.
// ----------------------------------------------------------------------------
package mcoc_pkg;

   // Store sizes
   localparam int MAX_DIMS   = 64;
   localparam int IDX_W      = $clog2(MAX_DIMS);
   localparam int CNT_W      = $clog2(MAX_DIMS + 1);
   localparam int CADDR_W    = 2 * IDX_W;
   localparam int COST_DEPTH = 1 << CADDR_W;

   // Datapath widths
   localparam int DIM_W   = 16;
   localparam int COST_W  = 60;
   localparam int PROD1_W = 2 * DIM_W;
   localparam int PROD_W  = 3 * DIM_W;

   typedef logic [DIM_W-1:0]   dim_type;
   typedef logic [COST_W-1:0]  cost_type;
   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [CNT_W-1:0]   cnt_type;
   typedef logic [CADDR_W-1:0] caddr_type;
   typedef logic [PROD1_W-1:0] prod1_type;
   typedef logic [PROD_W-1:0]  prod_type;

   localparam cost_type COST_MAX = {COST_W{1'b1}};

   // Dimension store access: one write port, two read ports
   typedef struct packed {
      logic    wr_en;
      idx_type wr_addr;
      dim_type wr_data;
      idx_type rd_addr_a;
      idx_type rd_addr_b;
   } dim_cmd_type;

   // Cost table access: row index in the upper half, column in the lower half
   typedef struct packed {
      logic      wr_en;
      caddr_type wr_addr;
      cost_type  wr_data;
      caddr_type rd_addr_a;
      caddr_type rd_addr_b;
   } cost_cmd_type;

   // Addition that sticks at the top of the cost range
   function automatic cost_type sat_add(input cost_type a, input cost_type b);
      logic [COST_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
   endfunction

endpackage

>>> src/mcoc_chan_if.sv
// ----------------------------------------------------------------------------
// mcoc_chan_if
// Valid/ready channels of the block: dimension items in, cost items out.
// ----------------------------------------------------------------------------
interface mcoc_req_if;
   import mcoc_pkg::*;

   logic    valid;
   logic    ready;
   dim_type dimension;
   logic    last;

   modport source (output valid, output dimension, output last, input ready);
   modport sink   (input valid, input dimension, input last, output ready);
endinterface

interface mcoc_rsp_if;
   import mcoc_pkg::*;

   logic     valid;
   logic     ready;
   cost_type min_cost;
   logic     overflow;

   modport source (output valid, output min_cost, output overflow, input ready);
   modport sink   (input valid, input min_cost, input overflow, output ready);
endinterface

>>> src/matrix_chain_order_cost.sv
// ----------------------------------------------------------------------------
// matrix_chain_order_cost
// Minimal scalar multiplication count of a matrix chain, by interval DP.
// ----------------------------------------------------------------------------
// Dimensions arrive one item per cycle, up to 64 per chain; the item marked
// last closes the chain. A chain of n dimensions holds m = n - 1 matrices.
// Chains of two or fewer dimensions, and chains that overflowed the store
// (min_cost 0, overflow 1), answer on the cycle after the last item. Longer
// chains run the bottom-up interval program over a cost table in memory: each
// interval takes one split point per cycle through the two cost-table read
// ports, after a setup and before a pipeline drain. No dimension item is
// taken while that program runs, nor while a finished result still waits on
// the response channel. Every sum saturates at 2^60 - 1.
module matrix_chain_order_cost (
   input logic        clock,
   input logic        reset,
   mcoc_req_if.sink   req_chan,
   mcoc_rsp_if.source rsp_chan
);
   import mcoc_pkg::*;

   dim_cmd_type  dim_cmd;
   cost_cmd_type cost_cmd;
   dim_type      dim_rd_a;
   dim_type      dim_rd_b;
   cost_type     cost_rd_a;
   cost_type     cost_rd_b;

   // Sequencer and arithmetic
   mcoc_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .rsp       (rsp_chan),
      .dim_cmd   (dim_cmd),
      .dim_rd_a  (dim_rd_a),
      .dim_rd_b  (dim_rd_b),
      .cost_cmd  (cost_cmd),
      .cost_rd_a (cost_rd_a),
      .cost_rd_b (cost_rd_b)
   );

   // Dimension store
   mcoc_dim_store u_dim_store (
      .clock     (clock),
      .cmd       (dim_cmd),
      .rd_data_a (dim_rd_a),
      .rd_data_b (dim_rd_b)
   );

   // Cost table
   mcoc_cost_store u_cost_store (
      .clock     (clock),
      .cmd       (cost_cmd),
      .rd_data_a (cost_rd_a),
      .rd_data_b (cost_rd_b)
   );

   // Dimensions are written only by an accepted item
   assert property (@(posedge clock) disable iff (reset)
      dim_cmd.wr_en |-> (req_chan.valid && req_chan.ready))
      else $error("dimension store written without an accepted item");

   // The table is never updated while a chain is loading
   assert property (@(posedge clock) disable iff (reset)
      cost_cmd.wr_en |-> !req_chan.ready)
      else $error("cost table written while loading");

   // Only intervals of two or more matrices are stored: row below column
   assert property (@(posedge clock) disable iff (reset)
      cost_cmd.wr_en |->
         (cost_cmd.wr_addr[CADDR_W-1:IDX_W] < cost_cmd.wr_addr[IDX_W-1:0]))
      else $error("cost table write outside the upper triangle");

endmodule

>>> src/mcoc_dim_store.sv
// ----------------------------------------------------------------------------
// mcoc_dim_store
// Dimension memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module mcoc_dim_store (
   input  logic                  clock,
   input  mcoc_pkg::dim_cmd_type cmd,
   output mcoc_pkg::dim_type     rd_data_a,
   output mcoc_pkg::dim_type     rd_data_b
);
   import mcoc_pkg::*;

   dim_type store_ff [MAX_DIMS];
   dim_type rd_a_ff;
   dim_type rd_b_ff;

   // Write, then registered reads
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         store_ff[cmd.wr_addr] <= cmd.wr_data;
      end
      rd_a_ff <= store_ff[cmd.rd_addr_a];
      rd_b_ff <= store_ff[cmd.rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

>>> src/mcoc_cost_store.sv
// ----------------------------------------------------------------------------
// mcoc_cost_store
// Interval cost table: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module mcoc_cost_store (
   input  logic                   clock,
   input  mcoc_pkg::cost_cmd_type cmd,
   output mcoc_pkg::cost_type     rd_data_a,
   output mcoc_pkg::cost_type     rd_data_b
);
   import mcoc_pkg::*;

   cost_type store_ff [COST_DEPTH];
   cost_type rd_a_ff;
   cost_type rd_b_ff;

   // Write, then registered reads
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         store_ff[cmd.wr_addr] <= cmd.wr_data;
      end
      rd_a_ff <= store_ff[cmd.rd_addr_a];
      rd_b_ff <= store_ff[cmd.rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

>>> src/mcoc_engine.sv
// ----------------------------------------------------------------------------
// mcoc_engine
// Chain loader and interval sequencer with a four stage split-point pipeline.
// ----------------------------------------------------------------------------
module mcoc_engine (
   input  logic                   clock,
   input  logic                   reset,
   mcoc_req_if.sink               req,
   mcoc_rsp_if.source             rsp,
   output mcoc_pkg::dim_cmd_type  dim_cmd,
   input  mcoc_pkg::dim_type      dim_rd_a,
   input  mcoc_pkg::dim_type      dim_rd_b,
   output mcoc_pkg::cost_cmd_type cost_cmd,
   input  mcoc_pkg::cost_type     cost_rd_a,
   input  mcoc_pkg::cost_type     cost_rd_b
);
   import mcoc_pkg::*;

   typedef enum logic [2:0] {
      S_LOAD,
      S_SETUP,
      S_CAPT,
      S_RUN,
      S_DRAIN
   } state_type;

   state_type state_ff;
   cnt_type   count_ff;
   logic      ovf_ff;
   idx_type   mats_ff;
   idx_type   len_ff;
   idx_type   i_ff;
   idx_type   k_ff;
   dim_type   d_i_ff;
   dim_type   d_j1_ff;
   cost_type  best_ff;
   logic      rsp_vld_ff;
   cost_type  rsp_cost_ff;
   logic      rsp_ovf_ff;

   // Pipeline registers
   logic      p1_vld_ff;
   logic      p1_lz_ff;
   logic      p1_rz_ff;
   logic      p2_vld_ff;
   cost_type  sum2_ff;
   prod1_type prod1_ff;
   logic      p3_vld_ff;
   cost_type  sum3_ff;
   prod_type  prod_ff;
   logic      p4_vld_ff;
   cost_type  cand_ff;

   logic      req_acc;
   logic      cnt_full;
   logic      ovf_now;
   cnt_type   count_in;
   idx_type   j_idx;
   idx_type   j_nx;
   idx_type   k_nx;
   idx_type   i_nx;
   logic      row_done;
   logic      pipe_busy;
   logic      issue;
   cost_type  left_cost;
   cost_type  right_cost;
   cost_type  sum2_in;
   prod1_type prod1_in;
   prod_type  prod_in;
   cost_type  cand_in;

   // Handshake: a chain loads only while the result slot is free or freeing
   assign req.ready   = (state_ff == S_LOAD) && (!rsp_vld_ff || rsp.ready);
   assign req_acc     = req.valid && req.ready;
   assign rsp.valid   = rsp_vld_ff;
   assign rsp.min_cost = rsp_cost_ff;
   assign rsp.overflow = rsp_ovf_ff;

   // Load bookkeeping
   assign cnt_full = (count_ff == CNT_W'(MAX_DIMS));
   assign ovf_now  = ovf_ff || cnt_full;
   assign count_in = cnt_full ? count_ff : count_ff + CNT_W'(1);

   // Interval indices
   assign j_idx = i_ff + len_ff - IDX_W'(1);
   assign j_nx  = j_idx + IDX_W'(1);
   assign k_nx  = k_ff + IDX_W'(1);
   assign i_nx  = i_ff + IDX_W'(1);
   assign row_done  = (CNT_W'(i_nx) + CNT_W'(len_ff)) > CNT_W'(mats_ff);
   assign pipe_busy = p1_vld_ff || p2_vld_ff || p3_vld_ff || p4_vld_ff;
   assign issue     = (state_ff == S_RUN);

   // Memory commands
   always_comb begin
      dim_cmd.wr_en     = req_acc && !cnt_full;
      dim_cmd.wr_addr   = count_ff[IDX_W-1:0];
      dim_cmd.wr_data   = req.dimension;
      dim_cmd.rd_addr_a = issue ? k_nx : i_ff;
      dim_cmd.rd_addr_b = j_nx;

      cost_cmd.wr_en     = (state_ff == S_DRAIN) && !pipe_busy;
      cost_cmd.wr_addr   = {i_ff, j_idx};
      cost_cmd.wr_data   = best_ff;
      cost_cmd.rd_addr_a = {i_ff, k_ff};
      cost_cmd.rd_addr_b = {k_nx, j_idx};
   end

   // Split-point datapath; diagonal costs are zero and never taken from memory
   assign left_cost  = p1_lz_ff ? '0 : cost_rd_a;
   assign right_cost = p1_rz_ff ? '0 : cost_rd_b;
   assign sum2_in    = sat_add(left_cost, right_cost);
   assign prod1_in   = PROD1_W'(d_i_ff) * PROD1_W'(dim_rd_a);
   assign prod_in    = PROD_W'(prod1_ff) * PROD_W'(d_j1_ff);
   assign cand_in    = sat_add(sum3_ff, COST_W'(prod_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         p3_vld_ff <= 1'b0;
         p4_vld_ff <= 1'b0;
      end else begin
         p1_vld_ff <= issue;
         p2_vld_ff <= p1_vld_ff;
         p3_vld_ff <= p2_vld_ff;
         p4_vld_ff <= p3_vld_ff;
      end
      p1_lz_ff <= (k_ff == i_ff);
      p1_rz_ff <= (k_nx == j_idx);
      sum2_ff  <= sum2_in;
      prod1_ff <= prod1_in;
      sum3_ff  <= sum2_ff;
      prod_ff  <= prod_in;
      cand_ff  <= cand_in;
   end

   // Sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_LOAD;
         count_ff   <= '0;
         ovf_ff     <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (rsp_vld_ff && rsp.ready) begin
            rsp_vld_ff <= 1'b0;
         end
         case (state_ff)
            S_LOAD: begin
               if (req_acc) begin
                  count_ff <= count_in;
                  ovf_ff   <= ovf_now;
                  if (req.last) begin
                     count_ff <= '0;
                     ovf_ff   <= 1'b0;
                     if (ovf_now || count_in <= CNT_W'(2)) begin
                        rsp_vld_ff  <= 1'b1;
                        rsp_cost_ff <= '0;
                        rsp_ovf_ff  <= ovf_now;
                     end else begin
                        mats_ff  <= IDX_W'(count_in - CNT_W'(1));
                        len_ff   <= IDX_W'(2);
                        i_ff     <= '0;
                        state_ff <= S_SETUP;
                     end
                  end
               end
            end
            S_SETUP: begin
               state_ff <= S_CAPT;
            end
            S_CAPT: begin
               d_i_ff   <= dim_rd_a;
               d_j1_ff  <= dim_rd_b;
               k_ff     <= i_ff;
               best_ff  <= COST_MAX;
               state_ff <= S_RUN;
            end
            S_RUN: begin
               k_ff <= k_nx;
               if (k_nx == j_idx) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               if (!pipe_busy) begin
                  if (!row_done) begin
                     i_ff     <= i_nx;
                     state_ff <= S_SETUP;
                  end else if (len_ff == mats_ff) begin
                     rsp_vld_ff  <= 1'b1;
                     rsp_cost_ff <= best_ff;
                     rsp_ovf_ff  <= 1'b0;
                     state_ff    <= S_LOAD;
                  end else begin
                     len_ff   <= len_ff + IDX_W'(1);
                     i_ff     <= '0;
                     state_ff <= S_SETUP;
                  end
               end
            end
            default: begin
               state_ff <= S_LOAD;
            end
         endcase
         // Running minimum over split points
         if (p4_vld_ff && cand_ff < best_ff) begin
            best_ff <= cand_ff;
         end
      end
   end

endmodule
